/* hdl/snbl_pkg.sv */
// Shared types and constants for the symbol nearest-below lookup engine.
// Used by the controller, datapath and top level.
package snbl_pkg;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_SORT   = 2'd2;
   localparam logic [1:0] OP_QUERY  = 2'd3;

   localparam logic [2:0] REG_SECTION_MASK = 3'd0;
   localparam logic [2:0] REG_CLASS_MASK   = 3'd1;
   localparam logic [2:0] REG_EXTERNAL     = 3'd2;
   localparam logic [2:0] REG_TEXT         = 3'd3;
   localparam logic [2:0] REG_DATA         = 3'd4;
   localparam logic [2:0] REG_BSS          = 3'd5;

   localparam int GAP_MUL = 3;
   localparam int GAP_FIRST = 4;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_GAP,        // append: store entry or flag full
      ST_PASS,       // start a pass: j = gap
      ST_JSTART,     // i = j - gap
      ST_RDA,        // read entry i
      ST_RDB,        // read entry i+gap
      ST_CMP,        // compare, maybe swap
      ST_WRB,        // write second half of swap
      ST_NEXTJ,
      ST_NEXTGAP,
      ST_BS_RD,      // binary search read mid
      ST_BS_CMP,
      ST_SC_RD,      // backward scan read
      ST_SC_CMP,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic       load_req;
      logic       clear_cnt;
      logic       append;
      logic       gap_init;
      logic       gap_grow;
      logic       gap_div;
      logic       j_init;
      logic       j_inc;
      logic       i_init;
      logic       i_dec;
      logic       rd_a;
      logic       rd_b;
      logic       latch_a;
      logic       latch_b;
      logic       wr_a;
      logic       wr_b;
      logic       bs_init;
      logic       bs_rd;
      logic       bs_upd;
      logic       sc_rd;
      logic       sc_dec;
      logic       set_hit;
      logic       clr_result;
      logic       set_full;
   } cmd_type;

   typedef struct packed {
      logic gap_can_grow;
      logic gap_is_one;
      logic j_done;
      logic i_neg;
      logic in_order;
      logic bs_done;
      logic sc_neg;
      logic sc_hit;
      logic full;
   } status_type;

endpackage

/* hdl/snbl_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module snbl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

/* hdl/snbl_datapath.sv */
// Datapath: table memory, sort indexes, search bounds and result registers.
// Depends on snbl_pkg and snbl_ram.
module snbl_datapath
   import snbl_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  stat,
   input  logic [31:0] req_entry_value,
   input  logic [7:0]  req_entry_class,
   input  logic [31:0] req_query_value,
   input  logic        req_query_in_text,
   input  logic [7:0]  section_mask,
   input  logic [7:0]  class_mask,
   input  logic [7:0]  external_class,
   input  logic [2:0]  text_section,
   input  logic [2:0]  data_section,
   input  logic [2:0]  bss_section,
   output logic        res_status,
   output logic        res_found,
   output logic [9:0]  res_match_index,
   output logic [31:0] res_symbol_value,
   output logic [31:0] res_offset,
   output logic        res_exact
);
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = AW + 1;
   localparam int SW = CW + 1;  // signed index width
   localparam int GW = CW + 2;  // gap width
   // gap / 3 as a reciprocal multiply, exact for any gap below 2^GW
   localparam int GAP_RECIP = ((1 << (GW + 2)) + GAP_MUL - 1) / GAP_MUL;

   logic [CW-1:0] count_ff;
   logic [CW+1:0] gap_ff, nxt_ff;   // room for 3*nxt+1
   logic [CW-1:0] j_ff;
   logic signed [SW-1:0] i_ff;
   logic signed [SW-1:0] left_ff, right_ff;
   logic [AW-1:0] mid;
   logic [31:0] a_val_ff, b_val_ff;
   logic [7:0]  a_cls_ff, b_cls_ff;
   logic [31:0] ev_ff, qv_ff;       // request beat held for the whole op
   logic [7:0]  ec_ff;
   logic        qt_ff;

   logic          we;
   logic [AW-1:0] addr;
   logic [31:0]   wv, rv;
   logic [7:0]    wc, rc;
   logic [SW-1:0] ib;
   logic signed [SW:0] lr_sum;
   logic [2*GW+1:0] gap_prod;

   snbl_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_vals (
      .clock(clock), .we(we), .addr(addr), .wdata(wv), .rdata(rv));
   snbl_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_cls (
      .clock(clock), .we(we), .addr(addr), .wdata(wc), .rdata(rc));

   assign lr_sum = SW'(left_ff) + SW'(right_ff);
   assign mid = AW'(lr_sum >>> 1);
   assign ib = SW'(i_ff) + SW'(gap_ff);
   assign gap_prod = (2*GW+2)'(gap_ff) * (2*GW+2)'(GAP_RECIP);

   always_comb begin
      we = 1'b0;
      addr = AW'(i_ff);
      wv = b_val_ff;
      wc = b_cls_ff;
      if (cmd.append) begin
         we = 1'b1;
         addr = count_ff[AW-1:0];
         wv = ev_ff;
         wc = ec_ff;
      end else if (cmd.rd_b || cmd.wr_b) begin
         addr = ib[AW-1:0];
         we = cmd.wr_b;
         wv = a_val_ff;
         wc = a_cls_ff;
      end else if (cmd.wr_a) begin
         we = 1'b1;
      end else if (cmd.rd_a) begin
         addr = AW'(i_ff);
      end else if (cmd.bs_rd) begin
         addr = mid;
      end else if (cmd.sc_rd) begin
         addr = AW'(right_ff);
      end
   end

   logic cls_ok, sec_hit;
   logic [7:0] sec;
   assign sec = rc & section_mask;
   assign cls_ok = (rc & class_mask) == external_class;
   assign sec_hit = qt_ff ? (sec == {5'd0, text_section})
      : (sec == {5'd0, data_section} || sec == {5'd0, bss_section});

   assign stat.gap_can_grow = (GAP_MUL * nxt_ff + 1) < (CW+2)'(count_ff);
   assign stat.gap_is_one   = gap_ff == (CW+2)'(1);
   assign stat.j_done       = j_ff >= count_ff;
   assign stat.i_neg        = i_ff < 0;
   assign stat.in_order     = $signed(a_val_ff) <= $signed(b_val_ff);
   assign stat.bs_done      = left_ff > right_ff;
   assign stat.sc_neg       = right_ff < 0;
   assign stat.sc_hit       = cls_ok && sec_hit;
   assign stat.full         = count_ff >= CW'(TABLE_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.clear_cnt) begin
         count_ff <= '0;
      end else if (cmd.append) begin
         count_ff <= count_ff + 1'b1;
      end

      if (cmd.load_req) begin
         ev_ff <= req_entry_value;
         ec_ff <= req_entry_class;
         qv_ff <= req_query_value;
         qt_ff <= req_query_in_text;
      end

      if (cmd.gap_init) begin
         gap_ff <= (CW+2)'(1);
         nxt_ff <= (CW+2)'(GAP_FIRST);
      end else if (cmd.gap_grow) begin
         gap_ff <= nxt_ff;
         nxt_ff <= (CW+2)'(GAP_MUL * nxt_ff + 1);
      end else if (cmd.gap_div) begin
         gap_ff <= gap_prod[GW+2 +: GW];
      end

      if (cmd.j_init) j_ff <= CW'(gap_ff);
      else if (cmd.j_inc) j_ff <= j_ff + 1'b1;

      if (cmd.i_init) i_ff <= SW'(j_ff) - SW'(gap_ff);
      else if (cmd.i_dec) i_ff <= i_ff - SW'(gap_ff);

      if (cmd.latch_a) begin
         a_val_ff <= rv;
         a_cls_ff <= rc;
      end
      if (cmd.latch_b) begin
         b_val_ff <= rv;
         b_cls_ff <= rc;
      end

      if (cmd.bs_init) begin
         left_ff <= '0;
         right_ff <= SW'(count_ff) - 1'b1;
      end else if (cmd.bs_upd) begin
         if ($signed(rv) > $signed(qv_ff)) right_ff <= SW'(mid) - 1'b1;
         else left_ff <= SW'(mid) + 1'b1;
      end else if (cmd.sc_dec) begin
         right_ff <= right_ff - 1'b1;
      end

      if (cmd.clr_result) begin
         res_status <= 1'b0;
         res_found <= 1'b0;
         res_match_index <= '0;
         res_symbol_value <= '0;
         res_offset <= '0;
         res_exact <= 1'b0;
      end else if (cmd.set_full) begin
         res_status <= 1'b1;
      end else if (cmd.set_hit) begin
         res_found <= 1'b1;
         res_match_index <= 10'(right_ff);
         res_symbol_value <= rv;
         res_offset <= qv_ff - rv;
         res_exact <= qv_ff == rv;
      end
   end
endmodule

/* hdl/snbl_ctrl.sv */
// Controller state machine for the lookup engine.
// Depends on snbl_pkg.
module snbl_ctrl
   import snbl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_opcode,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output cmd_type    cmd,
   input  status_type stat
);
   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic take;

   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign take = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               cmd.clr_result = 1'b1;
               cmd.load_req = 1'b1;
               unique case (req_opcode)
                  OP_CLEAR: begin
                     cmd.clear_cnt = 1'b1;
                     state_in = ST_RESP;
                  end
                  OP_APPEND: state_in = ST_GAP;  // reuse: decide full next
                  OP_SORT: begin
                     cmd.gap_init = 1'b1;
                     state_in = ST_NEXTGAP;
                  end
                  OP_QUERY: begin
                     cmd.bs_init = 1'b1;
                     state_in = ST_BS_RD;
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_GAP: begin
            if (stat.full) cmd.set_full = 1'b1;
            else cmd.append = 1'b1;
            state_in = ST_RESP;
         end
         ST_NEXTGAP: begin  // grow gap until done
            if (stat.gap_can_grow) cmd.gap_grow = 1'b1;
            else state_in = ST_PASS;
         end
         ST_PASS: begin
            cmd.j_init = 1'b1;
            state_in = ST_NEXTJ;
         end
         ST_NEXTJ: begin
            if (stat.j_done) begin
               if (stat.gap_is_one) state_in = ST_RESP;
               else begin
                  cmd.gap_div = 1'b1;
                  state_in = ST_PASS;
               end
            end else begin
               cmd.i_init = 1'b1;
               state_in = ST_JSTART;
            end
         end
         ST_JSTART: begin
            if (stat.i_neg) begin
               cmd.j_inc = 1'b1;
               state_in = ST_NEXTJ;
            end else begin
               cmd.rd_a = 1'b1;
               state_in = ST_RDA;
            end
         end
         ST_RDA: begin
            cmd.latch_a = 1'b1;
            cmd.rd_b = 1'b1;
            state_in = ST_RDB;
         end
         ST_RDB: begin
            cmd.latch_b = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (stat.in_order) begin
               cmd.j_inc = 1'b1;
               state_in = ST_NEXTJ;
            end else begin
               cmd.wr_a = 1'b1;  // entry i <- b
               state_in = ST_WRB;
            end
         end
         ST_WRB: begin
            cmd.wr_b = 1'b1;     // entry i+gap <- a
            cmd.i_dec = 1'b1;
            state_in = ST_JSTART;
         end
         ST_BS_RD: begin
            if (stat.bs_done) state_in = ST_SC_RD;
            else begin
               cmd.bs_rd = 1'b1;
               state_in = ST_BS_CMP;
            end
         end
         ST_BS_CMP: begin
            cmd.bs_upd = 1'b1;
            state_in = ST_BS_RD;
         end
         ST_SC_RD: begin
            if (stat.sc_neg) state_in = ST_RESP;
            else begin
               cmd.sc_rd = 1'b1;
               state_in = ST_SC_CMP;
            end
         end
         ST_SC_CMP: begin
            if (stat.sc_hit) begin
               cmd.set_hit = 1'b1;
               state_in = ST_RESP;
            end else begin
               cmd.sc_dec = 1'b1;
               state_in = ST_SC_RD;
            end
         end
         ST_RESP: begin
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

/* hdl/symbol_nearest_below_lookup_top.sv */
// Top level of the symbol nearest-below lookup engine.
// Depends on snbl_pkg, snbl_ctrl, snbl_datapath, snbl_ram.
//
//  channel | handshake           | beat contents
//  req     | req_valid/req_stall | opcode, entry value/class, query value/in_text
//  rsp     | rsp_valid/rsp_stall | status, found, index, value, offset, exact
//  csr     | csr_valid/csr_ready | register index, write data
//
// A query runs a binary search and then scans back entry by entry. Sort walks
// the table through the single RAM port: each compare reads both entries in
// turn, and a swap writes them back one after the other.
// The request beat is held inside at accept. Reset is synchronous and clears
// count, configuration registers and control; table contents stay undefined.
// A new beat is taken only once the previous result has left the output register.
module symbol_nearest_below_lookup_top
   import snbl_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic signed [31:0] req_entry_value,
   input  logic [7:0]  req_entry_class,
   input  logic signed [31:0] req_query_value,
   input  logic        req_query_in_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_status,
   output logic        rsp_found,
   output logic [9:0]  rsp_match_index,
   output logic signed [31:0] rsp_symbol_value,
   output logic [31:0] rsp_offset,
   output logic        rsp_exact,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data
);
   cmd_type    cmd;
   status_type stat;
   logic [7:0] section_mask_ff, class_mask_ff, external_ff;
   logic [2:0] text_ff, data_ff, bss_ff;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         section_mask_ff <= 8'd7;
         class_mask_ff <= 8'd248;
         external_ff <= 8'd16;
         text_ff <= 3'd2;
         data_ff <= 3'd3;
         bss_ff <= 3'd4;
      end else if (csr_valid) begin
         case (csr_index)
            REG_SECTION_MASK: section_mask_ff <= csr_data;
            REG_CLASS_MASK:   class_mask_ff <= csr_data;
            REG_EXTERNAL:     external_ff <= csr_data;
            REG_TEXT:         text_ff <= csr_data[2:0];
            REG_DATA:         data_ff <= csr_data[2:0];
            REG_BSS:          bss_ff <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   snbl_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_opcode(req_opcode),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .cmd(cmd), .stat(stat));

   snbl_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_entry_value(req_entry_value), .req_entry_class(req_entry_class),
      .req_query_value(req_query_value), .req_query_in_text(req_query_in_text),
      .section_mask(section_mask_ff), .class_mask(class_mask_ff),
      .external_class(external_ff), .text_section(text_ff),
      .data_section(data_ff), .bss_section(bss_ff),
      .res_status(rsp_status), .res_found(rsp_found),
      .res_match_index(rsp_match_index), .res_symbol_value(rsp_symbol_value),
      .res_offset(rsp_offset), .res_exact(rsp_exact));
endmodule

/* test/tb_symbol_nearest_below_lookup_top.sv */
// Self-checking testbench for symbol_nearest_below_lookup_top.
// Depends on snbl_pkg and the engine RTL. A queue-fed driver and a monitor check
// every response beat against an in-bench model of the table, sort and lookup.
module tb_symbol_nearest_below_lookup_top
   import snbl_pkg::*;
();

   localparam int DEPTH      = 1024;
   localparam int CYCLE_CAP  = 3000000;
   localparam int REPORT_MAX = 10;
   // index past the end of the register list; the engine drops such writes
   localparam logic [2:0] REG_UNUSED = 3'd7;

   typedef struct {
      logic [1:0]         op;
      logic signed [31:0] ev;
      logic [7:0]         ec;
      logic signed [31:0] qv;
      logic               qt;
   } beat_type;

   typedef struct {
      logic               status;
      logic               found;
      logic [9:0]         idx;
      logic signed [31:0] val;
      logic [31:0]        off;
      logic               exact;
   } lookup_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_opcode = OP_CLEAR;
   logic signed [31:0] req_entry_value = '0;
   logic [7:0] req_entry_class = '0;
   logic signed [31:0] req_query_value = '0;
   logic req_query_in_text = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_status, rsp_found, rsp_exact;
   logic [9:0] rsp_match_index;
   logic signed [31:0] rsp_symbol_value;
   logic [31:0] rsp_offset;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = REG_SECTION_MASK;
   logic [7:0] csr_data = '0;

   symbol_nearest_below_lookup_top u_top (.*);

   always #4 clock = ~clock;

   // ---------------------------------------------------------------
   // Model state: table copy plus the six control registers
   // ---------------------------------------------------------------
   logic signed [31:0] sym_val [DEPTH];
   logic [7:0]         sym_cls [DEPTH];
   int                 sym_cnt = 0;
   logic [7:0] m_sec = 8'd7, m_cls = 8'd248, m_ext = 8'd16;
   logic [2:0] m_text = 3'd2, m_data = 3'd3, m_bss = 3'd4;

   beat_type   pend_q[$];     // beats waiting for the driver
   lookup_type lookup_q[$];   // responses owed by the engine
   beat_type   cur_beat;
   int      err_cnt = 0;
   int      cycles = 0;
   bit      idle_on = 1'b1;
   int      gap_left = 0;
   int      stall_left = 0;

   // gapped insertion sort, gaps 1,4,13,... stopping at the first ordered pair
   function automatic void shell_sort_table();
      int gap = 1;
      int nxt = GAP_FIRST;
      logic signed [31:0] tv;
      logic [7:0] tc;
      while (GAP_MUL * nxt + 1 < sym_cnt) begin
         gap = nxt;
         nxt = GAP_MUL * nxt + 1;
      end
      do begin
         for (int j = gap; j < sym_cnt; j++) begin
            for (int i = j - gap; i >= 0; i -= gap) begin
               if (sym_val[i] <= sym_val[i + gap]) break;
               tv = sym_val[i]; sym_val[i] = sym_val[i + gap]; sym_val[i + gap] = tv;
               tc = sym_cls[i]; sym_cls[i] = sym_cls[i + gap]; sym_cls[i + gap] = tc;
            end
         end
         gap = gap / GAP_MUL;
      end while (gap != 0);
   endfunction

   // apply one beat to the model and return the response it owes
   function automatic lookup_type resolve_beat(beat_type b);
      lookup_type r = '{default: '0};
      int lo, hi, mid;
      logic [7:0] sec;
      bit hit;
      case (b.op)
         OP_CLEAR: sym_cnt = 0;
         OP_APPEND: begin
            if (sym_cnt >= DEPTH) r.status = 1'b1;
            else begin
               sym_val[sym_cnt] = b.ev;
               sym_cls[sym_cnt] = b.ec;
               sym_cnt++;
            end
         end
         OP_SORT: shell_sort_table();
         default: begin
            lo = 0;
            hi = sym_cnt - 1;
            while (lo <= hi) begin
               mid = (lo + hi) / 2;
               if (sym_val[mid] > b.qv) hi = mid - 1;
               else lo = mid + 1;
            end
            // walk back to the nearest external symbol of the wanted section
            for (int k = hi; k >= 0; k--) begin
               if ((sym_cls[k] & m_cls) != m_ext) continue;
               sec = sym_cls[k] & m_sec;
               hit = b.qt ? (sec == {5'd0, m_text})
                          : (sec == {5'd0, m_data} || sec == {5'd0, m_bss});
               if (hit) begin
                  r.found = 1'b1;
                  r.idx   = k[9:0];
                  r.val   = sym_val[k];
                  r.off   = b.qv - sym_val[k];
                  r.exact = (r.off == 0);
                  break;
               end
            end
         end
      endcase
      return r;
   endfunction

   // mostly zero, often short, now and then long
   function automatic int pick_gap();
      int r = $urandom_range(0, 99);
      if (!idle_on || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // ---------------------------------------------------------------
   // Request driver: beat is predicted at the edge it is accepted
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         if (req_valid && !req_stall) lookup_q.push_back(resolve_beat(cur_beat));
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pend_q.size() > 0) begin
               cur_beat = pend_q.pop_front();
               req_opcode        <= cur_beat.op;
               req_entry_value   <= cur_beat.ev;
               req_entry_class   <= cur_beat.ec;
               req_query_value   <= cur_beat.qv;
               req_query_in_text <= cur_beat.qt;
               req_valid         <= 1'b1;
               gap_left          <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Response monitor and random backpressure
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      lookup_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (lookup_q.size() == 0) begin
            err_cnt++;
            if (err_cnt <= REPORT_MAX) $display("unexpected response beat");
         end else begin
            e = lookup_q.pop_front();
            if (rsp_status !== e.status || rsp_found !== e.found ||
                rsp_match_index !== e.idx || rsp_symbol_value !== e.val ||
                rsp_offset !== e.off || rsp_exact !== e.exact) begin
               err_cnt++;
               if (err_cnt <= REPORT_MAX) begin
                  $write("mismatch: exp st=%0b f=%0b i=%0d v=%0d o=%h x=%0b",
                         e.status, e.found, e.idx, e.val, e.off, e.exact);
                  $display(" / got st=%0b f=%0b i=%0d v=%0d o=%h x=%0b",
                           rsp_status, rsp_found, rsp_match_index, rsp_symbol_value,
                           rsp_offset, rsp_exact);
               end
            end
         end
      end
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall  <= 1'b0;
         stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   logic signed [31:0] gen_vals[$];   // values appended since the last clear

   task automatic add(input logic [1:0] op, input logic signed [31:0] ev,
                      input logic [7:0] ec, input logic signed [31:0] qv,
                      input logic qt);
      beat_type b;
      b.op = op; b.ev = ev; b.ec = ec; b.qv = qv; b.qt = qt;
      if (op == OP_CLEAR) gen_vals.delete();
      if (op == OP_APPEND && gen_vals.size() < DEPTH) gen_vals.push_back(ev);
      pend_q.push_back(b);
   endtask

   function automatic logic signed [31:0] mk_value();
      int r = $urandom_range(0, 99);
      if (r < 60) return $signed($urandom_range(0, 200)) - 100;
      if (r < 85) return $urandom;
      case ($urandom_range(0, 3))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return 0;
         default: return -1;
      endcase
   endfunction

   // mostly external symbols of a wanted section under the current masks
   function automatic logic [7:0] mk_class();
      logic [7:0] sec;
      if ($urandom_range(0, 9) >= 7) return 8'($urandom);
      case ($urandom_range(0, 3))
         0: sec = {5'd0, m_text};
         1: sec = {5'd0, m_data};
         2: sec = {5'd0, m_bss};
         default: sec = 8'($urandom_range(0, 7));
      endcase
      return (m_ext & m_cls) | (sec & m_sec & ~m_cls) | (8'($urandom) & ~m_cls & ~m_sec);
   endfunction

   function automatic logic signed [31:0] mk_query();
      if (gen_vals.size() > 0 && $urandom_range(0, 9) < 7)
         return gen_vals[$urandom_range(0, gen_vals.size() - 1)]
                + $signed($urandom_range(0, 6)) - 2;
      return mk_value();
   endfunction

   task automatic add_query();
      add(OP_QUERY, $urandom, 8'($urandom), mk_query(), 1'($urandom_range(0, 1)));
   endtask

   task automatic add_append();
      add(OP_APPEND, mk_value(), mk_class(), $urandom, 1'($urandom_range(0, 1)));
   endtask

   // wait until the engine has drained everything
   task automatic wait_idle();
      while (pend_q.size() > 0 || req_valid || lookup_q.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         REG_SECTION_MASK: m_sec  = data;
         REG_CLASS_MASK:   m_cls  = data;
         REG_EXTERNAL:     m_ext  = data;
         REG_TEXT:         m_text = data[2:0];
         REG_DATA:         m_data = data[2:0];
         REG_BSS:          m_bss  = data[2:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_regs(input logic [7:0] s, c, e, input logic [2:0] t, d, b);
      write_reg(REG_SECTION_MASK, s);
      write_reg(REG_CLASS_MASK, c);
      write_reg(REG_EXTERNAL, e);
      write_reg(REG_TEXT, {5'd0, t});
      write_reg(REG_DATA, {5'd0, d});
      write_reg(REG_BSS, {5'd0, b});
   endtask

   // well-formed clear/fill/sort/query runs with some noise mixed in
   task automatic random_burst(input int n);
      int made = 0;
      int k;
      while (made < n) begin
         if ($urandom_range(0, 99) < 80) begin
            if ($urandom_range(0, 1)) begin
               add(OP_CLEAR, $urandom, 8'($urandom), $urandom, 1'b0);
               made++;
            end
            k = $urandom_range(1, 24);
            repeat (k) add_append();
            add(OP_SORT, $urandom, 8'($urandom), $urandom, 1'($urandom_range(0, 1)));
            made += k + 1;
            k = $urandom_range(2, 8);
            repeat (k) add_query();
            made += k;
         end else begin
            case ($urandom_range(0, 3))
               0: add(OP_CLEAR, $urandom, 8'($urandom), $urandom,
                      1'($urandom_range(0, 1)));
               1: add_append();
               2: add(OP_SORT, $urandom, 8'($urandom), $urandom,
                      1'($urandom_range(0, 1)));
               default: add_query();
            endcase
            made++;
         end
      end
   endtask

   // ---------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, extreme values, ties, class edge bytes
      add(OP_CLEAR, 0, 0, 0, 1'b0);
      add(OP_QUERY, 0, 0, 0, 1'b1);
      add(OP_APPEND, 32'sh8000_0000, 8'h12, 0, 1'b0);
      add(OP_APPEND, 32'sh7fff_ffff, 8'h12, 0, 1'b0);
      add(OP_APPEND, 0, 8'h13, 0, 1'b0);
      add(OP_APPEND, -1, 8'h14, 0, 1'b0);
      add(OP_APPEND, 0, 8'h12, 0, 1'b0);
      add(OP_APPEND, 5, 8'hff, 0, 1'b0);
      add(OP_APPEND, 5, 8'h00, 0, 1'b0);
      add(OP_QUERY, 0, 0, 3, 1'b1);              // unsorted search
      add(OP_SORT, 32'shffff_ffff, 8'hff, 32'shffff_ffff, 1'b1);
      add(OP_QUERY, 0, 0, 32'sh8000_0000, 1'b1);
      add(OP_QUERY, 0, 0, 32'sh7fff_ffff, 1'b1);
      add(OP_QUERY, 0, 0, 32'sh7fff_ffff, 1'b0);
      add(OP_QUERY, 0, 0, 0, 1'b1);
      add(OP_QUERY, 0, 0, 0, 1'b0);
      add(OP_QUERY, 0, 0, -2, 1'b0);
      add(OP_QUERY, 0, 0, 4, 1'b0);
      add(OP_SORT, 0, 0, 0, 1'b0);                // already in order
      add(OP_QUERY, 32'shffff_ffff, 8'hff, 100, 1'b1);
      wait_idle();

      // several register settings, extremes included
      set_regs(8'd7, 8'd248, 8'd16, 3'd2, 3'd3, 3'd4);
      random_burst(80);
      wait_idle();
      set_regs(8'd0, 8'd0, 8'd0, 3'd0, 3'd7, 3'd0);
      random_burst(70);
      wait_idle();
      set_regs(8'd255, 8'd0, 8'd0, 3'd5, 3'd1, 3'd6);
      random_burst(70);
      wait_idle();
      set_regs(8'd255, 8'd255, 8'd255, 3'd7, 3'd7, 3'd7);
      random_burst(40);
      wait_idle();
      write_reg(REG_UNUSED, 8'hff);               // must be dropped
      set_regs(8'd7, 8'd248, 8'd248, 3'd7, 3'd0, 3'd1);
      idle_on = 1'b0;                             // back-to-back stretch
      random_burst(90);
      wait_idle();
      idle_on = 1'b1;
      set_regs(8'd7, 8'd248, 8'd16, 3'd2, 3'd3, 3'd4);
      random_burst(90);
      wait_idle();

      // fill to capacity, refused appends, full-size sort and lookups
      add(OP_CLEAR, 0, 0, 0, 1'b0);
      repeat (DEPTH) add(OP_APPEND, $signed($urandom_range(0, 4000)) - 2000,
                         mk_class(), 0, 1'b0);
      repeat (3) add_append();
      repeat (3) add_query();
      add(OP_SORT, 0, 0, 0, 1'b0);
      repeat (8) add_query();
      add(OP_CLEAR, 0, 0, 0, 1'b0);
      add_query();
      wait_idle();

      repeat (50) @(posedge clock);
      if (err_cnt == 0 && lookup_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
